FILE: rtl/core/dns_question_parser_macros.svh
// Assertion helpers for the parser top module.
`ifndef DNS_QUESTION_PARSER_MACROS_SVH
`define DNS_QUESTION_PARSER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define DQP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DQP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dqp_pkg.sv
package dqp_pkg;

	localparam int POS_W       = 14;
	localparam int CHUNK_BYTES = 8;
	localparam int CCNT_W      = 4;
	localparam int NAME_START  = 12;
	localparam int HDR_BYTES   = 12;
	localparam int QTAIL_BYTES = 4;
	localparam int QDCOUNT_HI  = 4;
	localparam int QDCOUNT_LO  = 5;

	localparam logic [7:0] LABEL_TYPE_MASK = 8'hC0;
	localparam logic [7:0] PTR_HI_MASK     = 8'h3F;
	localparam logic [7:0] DOT_CHAR        = 8'h2E;
	localparam logic [7:0] UPPER_A         = 8'h41;
	localparam logic [7:0] UPPER_Z         = 8'h5A;
	localparam logic [7:0] CASE_OFFSET     = 8'h20;
	localparam logic [3:0] JUMPS_RESET     = 4'd8;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_NOQ   = 3'd2,
		ST_BAD   = 3'd3,
		ST_LONG  = 3'd4,
		ST_OVER  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CHECK,
		S_RDLEN,
		S_LEN,
		S_PRD,
		S_PTR,
		S_LRD,
		S_LWR,
		S_QT0,
		S_QT1,
		S_QT2,
		S_ERD,
		S_EWR,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic    load;
		logic    init_walk;
		logic    set_st;
		status_t st;
		logic    rd_en;
		logic    pos_inc;
		logic    lbl_begin;
		logic    ptr_take;
		logic    ptr_jump;
		logic    name_end;
		logic    char_wr;
		logic    qt_hi;
		logic    qt_lo;
		logic    emit_rd;
		logic    emit_wr;
		logic    final_res;
	} dqp_cmd_t;

	typedef struct packed {
		logic overflow;
		logic short_pkt;
		logic no_question;
		logic pos_ge_len;
		logic b_zero;
		logic b_ptr;
		logic b_resv;
		logic ptr_no2nd;
		logic jump_over;
		logic lbl_past;
		logic too_long;
		logic n_zero;
		logic cnt_one;
		logic qt_fit;
		logic emit_last;
	} dqp_sts_t;

endpackage

FILE: rtl/core/dqp_ctrl.sv
module dqp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             final_byte,
	input  dqp_pkg::dqp_sts_t sts,
	output dqp_pkg::dqp_cmd_t cmd,
	output logic             busy
);
	import dqp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (start && final_byte) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.overflow || sts.short_pkt || sts.no_question) begin
					state_d = S_FINAL;
				end else begin
					state_d = S_RDLEN;
				end
			end
			S_RDLEN: begin
				state_d = sts.pos_ge_len ? S_FINAL : S_LEN;
			end
			S_LEN: begin
				if (sts.b_zero) begin
					state_d = sts.n_zero ? S_FINAL : S_QT0;
				end else if (sts.b_ptr) begin
					state_d = (sts.ptr_no2nd || sts.jump_over) ? S_FINAL : S_PRD;
				end else if (sts.b_resv || sts.lbl_past || sts.too_long) begin
					state_d = S_FINAL;
				end else begin
					state_d = S_LRD;
				end
			end
			S_PRD:   state_d = S_PTR;
			S_PTR:   state_d = S_RDLEN;
			S_LRD:   state_d = S_LWR;
			S_LWR:   state_d = sts.cnt_one ? S_RDLEN : S_LRD;
			S_QT0:   state_d = sts.qt_fit ? S_QT1 : S_ERD;
			S_QT1:   state_d = S_QT2;
			S_QT2:   state_d = S_ERD;
			S_ERD:   state_d = S_EWR;
			S_EWR:   state_d = sts.emit_last ? S_FINAL : S_ERD;
			S_FINAL: state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.st = ST_OK;
		busy = 1'b1;
		case (state_q)
			S_LOAD: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_CHECK: begin
				if (sts.overflow) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_OVER;
				end else if (sts.short_pkt) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_SHORT;
				end else if (sts.no_question) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_NOQ;
				end else begin
					cmd.init_walk = 1'b1;
				end
			end
			S_RDLEN: begin
				if (sts.pos_ge_len) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_BAD;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			S_LEN: begin
				if (sts.b_zero) begin
					if (sts.n_zero) begin
						cmd.set_st = 1'b1;
						cmd.st = ST_BAD;
					end else begin
						cmd.name_end = 1'b1;
					end
				end else if (sts.b_ptr) begin
					if (sts.ptr_no2nd || sts.jump_over) begin
						cmd.set_st = 1'b1;
						cmd.st = ST_BAD;
					end else begin
						cmd.ptr_take = 1'b1;
					end
				end else if (sts.b_resv || sts.lbl_past) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_BAD;
				end else if (sts.too_long) begin
					cmd.set_st = 1'b1;
					cmd.st = ST_LONG;
				end else begin
					cmd.lbl_begin = 1'b1;
				end
			end
			S_PRD: begin
				cmd.rd_en = 1'b1;
			end
			S_PTR: begin
				cmd.ptr_jump = 1'b1;
			end
			S_LRD: begin
				cmd.rd_en = 1'b1;
				cmd.pos_inc = 1'b1;
			end
			S_LWR: begin
				cmd.char_wr = 1'b1;
			end
			S_QT0: begin
				if (sts.qt_fit) begin
					cmd.rd_en = 1'b1;
					cmd.pos_inc = 1'b1;
				end
			end
			S_QT1: begin
				cmd.qt_hi = 1'b1;
				cmd.rd_en = 1'b1;
			end
			S_QT2: begin
				cmd.qt_lo = 1'b1;
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
			end
			S_EWR: begin
				cmd.emit_wr = 1'b1;
			end
			S_FINAL: begin
				cmd.final_res = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/core/dqp_datapath.sv
module dqp_datapath #(
	parameter int PACKET_BYTES   = 512,
	parameter int MAX_NAME_CHARS = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        packet_byte,
	input  logic              cfg_write,
	input  logic [3:0]        cfg_data,
	input  dqp_pkg::dqp_cmd_t cmd,
	output dqp_pkg::dqp_sts_t sts,
	output logic              result_valid,
	output logic [63:0]       name_chunk,
	output logic [3:0]        chunk_count,
	output logic              end_of_name,
	output logic [2:0]        parse_status,
	output logic [15:0]       query_type,
	output logic [9:0]        question_end
);
	import dqp_pkg::*;

	localparam int AW  = $clog2(PACKET_BYTES);
	localparam int CW  = $clog2(PACKET_BYTES + 1);
	localparam int NBW = $clog2(MAX_NAME_CHARS + 1);
	localparam int NAW = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
	localparam int PX  = POS_W + 1;
	localparam int LW  = NBW + 8;
	localparam logic [CW-1:0] PKT_FULL = CW'(PACKET_BYTES);

	logic [7:0]        pkt_mem [PACKET_BYTES];
	logic [7:0]        name_mem [MAX_NAME_CHARS];

	logic [CW-1:0]     byte_cnt_q;
	logic              ovf_q;
	logic [7:0]        hdr_hi_q;
	logic [7:0]        hdr_lo_q;
	logic [3:0]        max_jumps_q;

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  end_q;
	logic              jumped_q;
	logic [3:0]        jumps_q;
	logic [5:0]        ptr_hi_q;
	logic [5:0]        lbl_cnt_q;
	logic [NBW-1:0]    n_q;
	logic [NBW-1:0]    e_q;
	logic [7:0]        pkt_rd_q;
	logic [7:0]        name_rd_q;
	status_t           st_q;
	logic [15:0]       qt_q;
	logic [63:0]       chunk_q;
	logic [CCNT_W-1:0] ccnt_q;

	logic              res_valid_q;
	logic [63:0]       res_chunk_q;
	logic [3:0]        res_count_q;
	logic              res_eon_q;
	logic [2:0]        res_status_q;
	logic [15:0]       res_qt_q;
	logic [9:0]        res_qe_q;

	logic [PX-1:0]     pos_x;
	logic [PX-1:0]     len_x;
	logic [PX-1:0]     b_x;
	logic [POS_W-1:0]  end_next;
	logic [7:0]        char_lc;
	logic              name_we;
	logic [7:0]        name_wdata;
	logic [63:0]       chunk_next;
	logic              chunk_close;
	logic              pkt_we;

	assign pos_x = PX'(pos_q);
	assign len_x = PX'(byte_cnt_q);
	assign b_x   = PX'(pkt_rd_q);

	always_comb begin
		sts = '0;
		sts.overflow    = ovf_q;
		sts.short_pkt   = byte_cnt_q < CW'(HDR_BYTES);
		sts.no_question = (hdr_hi_q == 8'd0) && (hdr_lo_q == 8'd0);
		sts.pos_ge_len  = pos_x >= len_x;
		sts.b_zero      = pkt_rd_q == 8'd0;
		sts.b_ptr       = (pkt_rd_q & LABEL_TYPE_MASK) == LABEL_TYPE_MASK;
		sts.b_resv      = ((pkt_rd_q & LABEL_TYPE_MASK) != 8'd0) &&
			((pkt_rd_q & LABEL_TYPE_MASK) != LABEL_TYPE_MASK);
		sts.ptr_no2nd   = (pos_x + PX'(1)) >= len_x;
		sts.jump_over   = jumps_q >= max_jumps_q;
		sts.lbl_past    = (pos_x + PX'(1) + b_x) > len_x;
		sts.too_long    = (LW'(n_q) + LW'(n_q != '0) + LW'(pkt_rd_q)) > LW'(MAX_NAME_CHARS);
		sts.n_zero      = n_q == '0;
		sts.cnt_one     = lbl_cnt_q == 6'd1;
		sts.qt_fit      = (PX'(end_q) + PX'(QTAIL_BYTES)) <= len_x;
		sts.emit_last   = e_q == n_q;
	end

	assign pkt_we = cmd.load && (byte_cnt_q < PKT_FULL);

	always_ff @(posedge clk) begin
		if (pkt_we) begin
			pkt_mem[byte_cnt_q[AW-1:0]] <= packet_byte;
		end
		if (cmd.rd_en) begin
			pkt_rd_q <= pkt_mem[pos_q[AW-1:0]];
		end
	end

	assign char_lc = ((pkt_rd_q >= UPPER_A) && (pkt_rd_q <= UPPER_Z)) ?
		(pkt_rd_q + CASE_OFFSET) : pkt_rd_q;
	assign name_we    = cmd.char_wr || (cmd.lbl_begin && (n_q != '0));
	assign name_wdata = cmd.char_wr ? char_lc : DOT_CHAR;

	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[n_q[NAW-1:0]] <= name_wdata;
		end
		if (cmd.emit_rd) begin
			name_rd_q <= name_mem[e_q[NAW-1:0]];
		end
	end

	assign end_next = jumped_q ? end_q : (pos_q + POS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			max_jumps_q <= JUMPS_RESET;
		end else begin
			if (cfg_write) begin
				max_jumps_q <= cfg_data;
			end
			if (cmd.final_res) begin
				byte_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end else if (cmd.load) begin
				if (pkt_we) begin
					byte_cnt_q <= byte_cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_we && (byte_cnt_q == CW'(QDCOUNT_HI))) begin
			hdr_hi_q <= packet_byte;
		end
		if (pkt_we && (byte_cnt_q == CW'(QDCOUNT_LO))) begin
			hdr_lo_q <= packet_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_walk) begin
			pos_q <= POS_W'(NAME_START);
		end else if (cmd.ptr_jump) begin
			pos_q <= {ptr_hi_q, pkt_rd_q};
		end else if (cmd.name_end) begin
			pos_q <= end_next;
		end else if (cmd.pos_inc || cmd.lbl_begin || cmd.ptr_take) begin
			pos_q <= pos_q + POS_W'(1);
		end

		if (cmd.init_walk) begin
			jumped_q <= 1'b0;
			jumps_q  <= '0;
			n_q      <= '0;
			e_q      <= '0;
			ccnt_q   <= '0;
			chunk_q  <= '0;
			qt_q     <= '0;
		end else begin
			if (cmd.ptr_take) begin
				jumped_q <= 1'b1;
				jumps_q  <= jumps_q + 4'd1;
				ptr_hi_q <= pkt_rd_q[5:0] & PTR_HI_MASK[5:0];
				if (!jumped_q) begin
					end_q <= pos_q + POS_W'(2);
				end
			end
			if (cmd.name_end) begin
				end_q <= end_next;
			end
			if (cmd.lbl_begin) begin
				lbl_cnt_q <= pkt_rd_q[5:0];
				if (n_q != '0) begin
					n_q <= n_q + NBW'(1);
				end
			end
			if (cmd.char_wr) begin
				n_q       <= n_q + NBW'(1);
				lbl_cnt_q <= lbl_cnt_q - 6'd1;
			end
			if (cmd.qt_hi) begin
				qt_q[15:8] <= pkt_rd_q;
			end
			if (cmd.qt_lo) begin
				qt_q[7:0] <= pkt_rd_q;
			end
			if (cmd.emit_rd) begin
				e_q <= e_q + NBW'(1);
			end
			if (cmd.emit_wr) begin
				if (chunk_close) begin
					chunk_q <= '0;
					ccnt_q  <= '0;
				end else begin
					chunk_q <= chunk_next;
					ccnt_q  <= ccnt_q + CCNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_OK;
		end else if (cmd.init_walk) begin
			st_q <= ST_OK;
		end else if (cmd.set_st) begin
			st_q <= cmd.st;
		end
	end

	always_comb begin
		chunk_next = chunk_q;
		for (int j = 0; j < CHUNK_BYTES; j++) begin
			if (ccnt_q == CCNT_W'(j)) begin
				chunk_next[8*j +: 8] = name_rd_q;
			end
		end
	end

	assign chunk_close = (ccnt_q == CCNT_W'(CHUNK_BYTES - 1)) || sts.emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (cmd.emit_wr && chunk_close) || cmd.final_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_wr) begin
			res_chunk_q  <= chunk_next;
			res_count_q  <= 4'(ccnt_q + CCNT_W'(1));
			res_eon_q    <= 1'b0;
			res_status_q <= ST_OK;
			res_qt_q     <= '0;
			res_qe_q     <= '0;
		end else if (cmd.final_res) begin
			res_chunk_q  <= '0;
			res_count_q  <= '0;
			res_eon_q    <= 1'b1;
			res_status_q <= st_q;
			if ((st_q == ST_OK) && (qt_q != '0 || sts.qt_fit)) begin
				res_qt_q <= qt_q;
				res_qe_q <= 10'(end_q + POS_W'(QTAIL_BYTES));
			end else begin
				res_qt_q <= '0;
				res_qe_q <= '0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign name_chunk   = res_chunk_q;
	assign chunk_count  = res_count_q;
	assign end_of_name  = res_eon_q;
	assign parse_status = res_status_q;
	assign query_type   = res_qt_q;
	assign question_end = res_qe_q;

endmodule

FILE: rtl/core/dns_question_parser.sv
// Packet bytes are taken one per cycle while busy is low and start is high; the byte marked
// final_byte starts the header check and the walk of the question name, and busy stays high
// until the last result has been issued. The walk is a sequencer around the single packet
// memory read port: each label length byte is read and then decoded, each name character is
// read and then written to the name buffer, a compression pointer also reads its second byte
// and jumps, and the qtype is read from the question tail when it fits; then the name is
// streamed out of the name buffer a character at a time. Each result word is shown for exactly
// one cycle with result_valid high and cannot be stalled, so the receiver must take every word
// as it appears. A failed packet gives only the final word.
`include "dns_question_parser_macros.svh"

module dns_question_parser #(
	parameter int PACKET_BYTES   = 512,
	parameter int MAX_NAME_CHARS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  packet_byte,
	input  logic        final_byte,
	input  logic        cfg_write,
	input  logic [3:0]  cfg_data,
	output logic        result_valid,
	output logic [63:0] name_chunk,
	output logic [3:0]  chunk_count,
	output logic        end_of_name,
	output logic [2:0]  parse_status,
	output logic [15:0] query_type,
	output logic [9:0]  question_end
);
	import dqp_pkg::*;

	dqp_cmd_t cmd;
	dqp_sts_t sts;

	dqp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_byte (final_byte),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	dqp_datapath #(
		.PACKET_BYTES   (PACKET_BYTES),
		.MAX_NAME_CHARS (MAX_NAME_CHARS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.packet_byte  (packet_byte),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.name_chunk   (name_chunk),
		.chunk_count  (chunk_count),
		.end_of_name  (end_of_name),
		.parse_status (parse_status),
		.query_type   (query_type),
		.question_end (question_end)
	);

	`DQP_ASSERT_NOW(a_chunk_count_range, result_valid && !end_of_name, (chunk_count != 4'd0) && (chunk_count <= 4'(CHUNK_BYTES)), "Name word with a bad character count.")
	`DQP_ASSERT_NOW(a_fail_no_qtype, result_valid && end_of_name && (parse_status != ST_OK), (query_type == 16'd0) && (question_end == 10'd0), "Failed packet reports a qtype or an end offset.")
	`DQP_ASSERT_NEXT(a_final_starts_walk, start && !busy && final_byte, busy, "Final byte did not start the walk.")
	`DQP_ASSERT_NOW(a_final_idle, result_valid && end_of_name, !busy, "Final word issued while the walk is still running.")

endmodule
